### rtl/bmhq_pkg.sv
// Shared types, constants and helpers for the binary min-heap queue.
`timescale 1ns / 1ps

package bmhq_pkg;

	// Heap geometry
	localparam int HEAP_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
	localparam int SLOT_W     = SIZE_W + 1;
	localparam int VALUE_W    = 31;
	localparam int STATUS_W   = 2;

	// Command codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               opcode;
		logic [VALUE_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  min_value;
		logic [STATUS_W-1:0] status;
		logic [SIZE_W-1:0]   entry_count;
	} out_t;

	// Finished operation handed from the sequencer to the output register
	typedef struct packed {
		logic valid;
		out_t res;
	} fin_t;

	// One-based heap slot to zero-based memory address
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot);
		logic [SLOT_W-1:0] tmp;
		begin
			tmp = slot - SLOT_W'(1);
			return tmp[ADDR_W-1:0];
		end
	endfunction

endpackage

### rtl/bmhq_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module bmhq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 31,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register both reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### rtl/bmhq_ctrl.sv
// Sift sequencer: walks the heap in memory one level per cycle.
`timescale 1ns / 1ps

module bmhq_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  bmhq_pkg::in_t                  cmd,
	output logic                           idle,
	output bmhq_pkg::fin_t                 fin,
	output logic                           ram_we,
	output logic [bmhq_pkg::ADDR_W-1:0]    ram_waddr,
	output logic [bmhq_pkg::VALUE_W-1:0]   ram_wdata,
	output logic [bmhq_pkg::ADDR_W-1:0]    ram_raddr_a,
	output logic [bmhq_pkg::ADDR_W-1:0]    ram_raddr_b,
	input  logic [bmhq_pkg::VALUE_W-1:0]   ram_rdata_a,
	input  logic [bmhq_pkg::VALUE_W-1:0]   ram_rdata_b
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UP   = 3'd1;
	localparam logic [2:0] S_DNLD = 3'd2;
	localparam logic [2:0] S_DN   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]                     state_q, state_d;
	logic [bmhq_pkg::SIZE_W-1:0]    size_q, size_d;
	logic [bmhq_pkg::SLOT_W-1:0]    slot_q, slot_d;
	logic [bmhq_pkg::VALUE_W-1:0]   key_q, key_d;
	logic [bmhq_pkg::VALUE_W-1:0]   top_q, top_d;
	logic                           op_q, op_d;

	logic [bmhq_pkg::SLOT_W-1:0]    size_x;
	logic [bmhq_pkg::SLOT_W-1:0]    parent;
	logic [bmhq_pkg::SLOT_W-1:0]    child;
	logic [bmhq_pkg::SLOT_W-1:0]    right;
	logic                           use_right;
	logic [bmhq_pkg::SLOT_W-1:0]    pick;
	logic [bmhq_pkg::VALUE_W-1:0]   pick_val;
	logic [bmhq_pkg::SLOT_W-1:0]    next_child;

	assign idle = (state_q == S_IDLE);

	// Tree neighbours of the current slot
	assign size_x     = bmhq_pkg::SLOT_W'(size_q);
	assign parent     = slot_q >> 1;
	assign child      = slot_q << 1;
	assign right      = child + bmhq_pkg::SLOT_W'(1);
	assign use_right  = (right <= size_x) && (ram_rdata_a > ram_rdata_b);
	assign pick       = use_right ? right : child;
	assign pick_val   = use_right ? ram_rdata_b : ram_rdata_a;
	assign next_child = pick << 1;

	// Sequence: each step writes one slot and reads the next level, never the
	// slot being written, so no forwarding is needed
	always_comb begin
		state_d     = state_q;
		size_d      = size_q;
		slot_d      = slot_q;
		key_d       = key_q;
		top_d       = top_q;
		op_d        = op_q;
		ram_we      = 1'b0;
		ram_waddr   = bmhq_pkg::slot_addr(slot_q);
		ram_wdata   = key_q;
		ram_raddr_a = '0;
		ram_raddr_b = '0;
		fin         = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d = cmd.opcode;
					if (cmd.opcode == bmhq_pkg::OP_PUSH) begin
						if (size_q == bmhq_pkg::SIZE_W'(bmhq_pkg::HEAP_DEPTH)) begin
							fin.valid           = 1'b1;
							fin.res.status      = bmhq_pkg::ST_FULL;
							fin.res.entry_count = size_q;
						end else if (size_q == '0) begin
							ram_we              = 1'b1;
							ram_waddr           = '0;
							ram_wdata           = cmd.value;
							size_d              = bmhq_pkg::SIZE_W'(1);
							fin.valid           = 1'b1;
							fin.res.status      = bmhq_pkg::ST_OK;
							fin.res.entry_count = bmhq_pkg::SIZE_W'(1);
						end else begin
							slot_d      = size_x + bmhq_pkg::SLOT_W'(1);
							key_d       = cmd.value;
							size_d      = size_q + bmhq_pkg::SIZE_W'(1);
							ram_raddr_a = bmhq_pkg::slot_addr(
								(size_x + bmhq_pkg::SLOT_W'(1)) >> 1);
							state_d     = S_UP;
						end
					end else begin
						if (size_q == '0) begin
							fin.valid           = 1'b1;
							fin.res.status      = bmhq_pkg::ST_EMPTY;
							fin.res.entry_count = size_q;
						end else begin
							ram_raddr_a = '0;
							ram_raddr_b = bmhq_pkg::slot_addr(size_x);
							size_d      = size_q - bmhq_pkg::SIZE_W'(1);
							state_d     = S_DNLD;
						end
					end
				end
			end
			// Sift up: parent data arrived, move it down or settle here
			S_UP: begin
				ram_we = 1'b1;
				if (key_q < ram_rdata_a) begin
					ram_wdata = ram_rdata_a;
					slot_d    = parent;
					if (parent != bmhq_pkg::SLOT_W'(1)) begin
						ram_raddr_a = bmhq_pkg::slot_addr(parent >> 1);
					end else begin
						state_d = S_FIN;
					end
				end else begin
					fin.valid           = 1'b1;
					fin.res.status      = bmhq_pkg::ST_OK;
					fin.res.entry_count = size_q;
					state_d             = S_IDLE;
				end
			end
			// Pop: latch root and last entry, start at the root
			S_DNLD: begin
				top_d  = ram_rdata_a;
				key_d  = ram_rdata_b;
				slot_d = bmhq_pkg::SLOT_W'(1);
				if (bmhq_pkg::SLOT_W'(2) <= size_x) begin
					ram_raddr_a = bmhq_pkg::slot_addr(bmhq_pkg::SLOT_W'(2));
					ram_raddr_b = bmhq_pkg::slot_addr(bmhq_pkg::SLOT_W'(3));
					state_d     = S_DN;
				end else begin
					state_d = S_FIN;
				end
			end
			// Sift down: children arrived, promote the smaller or settle
			S_DN: begin
				if (pick_val > key_q) begin
					state_d = S_FIN;
				end else begin
					ram_we    = 1'b1;
					ram_wdata = pick_val;
					slot_d    = pick;
					if (next_child <= size_x) begin
						ram_raddr_a = bmhq_pkg::slot_addr(next_child);
						ram_raddr_b = bmhq_pkg::slot_addr(next_child + bmhq_pkg::SLOT_W'(1));
					end else begin
						state_d = S_FIN;
					end
				end
			end
			// Drop the held key into its final slot
			S_FIN: begin
				ram_we              = 1'b1;
				fin.valid           = 1'b1;
				fin.res.min_value   = (op_q == bmhq_pkg::OP_POP) ? top_q : '0;
				fin.res.status      = bmhq_pkg::ST_OK;
				fin.res.entry_count = size_q;
				state_d             = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q  <= '0;
		end else begin
			state_q <= state_d;
			size_q  <= size_d;
		end
	end

	// Working payload
	always_ff @(posedge clk) begin
		slot_q <= slot_d;
		key_q  <= key_d;
		top_q  <= top_d;
		op_q   <= op_d;
	end

endmodule

### rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue top level.
// A push into an empty heap, a full push or an empty pop finishes straight from idle;
//   other pushes sift up, and pops latch the root and last entry, then sift down,
//   one memory level per cycle of the sift walk.
// Throughput: one command at a time; the next may start in the cycle its result shows.
// Reset clears the entry count and control; the heap memory is not swept.
`timescale 1ns / 1ps

module binary_min_heap_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bmhq_pkg::in_t  cmd,
	output logic           done,
	output bmhq_pkg::out_t result
);

	logic                          accept;
	logic                          idle;
	bmhq_pkg::fin_t                fin;
	logic                          ram_we;
	logic [bmhq_pkg::ADDR_W-1:0]   ram_waddr;
	logic [bmhq_pkg::VALUE_W-1:0]  ram_wdata;
	logic [bmhq_pkg::ADDR_W-1:0]   ram_raddr_a;
	logic [bmhq_pkg::ADDR_W-1:0]   ram_raddr_b;
	logic [bmhq_pkg::VALUE_W-1:0]  ram_rdata_a;
	logic [bmhq_pkg::VALUE_W-1:0]  ram_rdata_b;
	logic                          done_q;
	bmhq_pkg::out_t                result_q;

	assign busy   = !idle;
	assign accept = start && idle;

	bmhq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.idle        (idle),
		.fin         (fin),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr_a (ram_raddr_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b)
	);

	bmhq_ram #(
		.DEPTH (bmhq_pkg::HEAP_DEPTH),
		.WIDTH (bmhq_pkg::VALUE_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
		end
	end

	// Result beat
	always_ff @(posedge clk) begin
		if (fin.valid) begin
			result_q <= fin.res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// An accepted command is either still in work or has just finished
	a_accept_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted command neither in work nor finished");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.entry_count <= bmhq_pkg::SIZE_W'(bmhq_pkg::HEAP_DEPTH)))
		else $error("entry count beyond heap depth");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == bmhq_pkg::ST_EMPTY) |->
		(result.entry_count == '0 && result.min_value == '0))
		else $error("empty pop reported with entries or a value");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == bmhq_pkg::ST_FULL) |->
		(result.entry_count == bmhq_pkg::SIZE_W'(bmhq_pkg::HEAP_DEPTH)))
		else $error("dropped push reported on a heap that is not full");

endmodule

### bench/tb_binary_min_heap_queue.sv
// Self-checking testbench for the binary min-heap priority queue.
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
	import bmhq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 30;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	// Shadow copy of the heap: works out the result beat of every accepted command
	class heap_shadow;
		logic [VALUE_W-1:0] slots [1:HEAP_DEPTH];
		int unsigned        fill;
		out_t               awaited_beats[$];
		int unsigned        mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		// Apply one accepted command and queue the beat it must produce
		function void note_command(in_t c);
			out_t               beat;
			logic [VALUE_W-1:0] v;
			logic [VALUE_W-1:0] last;
			int unsigned        slot;
			int unsigned        parent;
			int unsigned        child;
			beat = '0;
			beat.status = ST_OK;
			if (c.opcode == OP_PUSH) begin
				if (fill >= HEAP_DEPTH) begin
					beat.status = ST_FULL;
				end else begin
					// Sift up past strictly larger parents
					v = c.value;
					slot = fill + 1;
					while (slot > 1 && v < slots[slot / 2]) begin
						slots[slot] = slots[slot / 2];
						slot = slot / 2;
					end
					slots[slot] = v;
					fill++;
				end
			end else if (fill == 0) begin
				beat.status = ST_EMPTY;
			end else begin
				// Take the root, move the last entry down toward the smaller child
				beat.min_value = slots[1];
				last = slots[fill];
				fill--;
				parent = 1;
				child = 2;
				while (child <= fill) begin
					if (child + 1 <= fill && slots[child] > slots[child + 1])
						child++;
					if (slots[child] > last)
						break;
					slots[parent] = slots[child];
					parent = child;
					child = child * 2;
				end
				slots[parent] = last;
			end
			beat.entry_count = fill[SIZE_W-1:0];
			awaited_beats.push_back(beat);
		endfunction

		// Compare a result beat with the oldest awaited one
		function void check_result(out_t got);
			out_t want;
			if (awaited_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: min=%0d status=%0d count=%0d",
						got.min_value, got.status, got.entry_count);
				return;
			end
			want = awaited_beats.pop_front();
			if (got.min_value !== want.min_value || got.status !== want.status ||
				got.entry_count !== want.entry_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected min=%0d status=%0d count=%0d, got min=%0d status=%0d count=%0d",
						want.min_value, want.status, want.entry_count,
						got.min_value, got.status, got.entry_count);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t  cmd = '0;
	logic done;
	out_t result;

	heap_shadow  shadow;
	int unsigned cycles = 0;
	int          burst_left = 0;

	binary_min_heap_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Guard against a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_binary_min_heap_queue NOT OK");
			$finish;
		end
	end

	// Check every result beat on its strobe
	always @(posedge clk) begin
		if (arst_n && done)
			shadow.check_result(result);
	end

	// Mix of extremes, single bits, small values (for equal keys) and full-range values
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = VALUE_MAX;
			2, 3, 4: v = VALUE_W'($urandom_range(0, 15));
			5: v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
			default: v = VALUE_W'($urandom);
		endcase
		return v;
	endfunction

	// Present one command and hold it until the block takes the beat
	task automatic send(input logic op, input logic [VALUE_W-1:0] v);
		start <= 1'b1;
		cmd <= '{opcode: op, value: v};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		shadow.note_command(cmd);
	endtask

	// Drop start, with noise on the ignored command lines
	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			cmd <= '{opcode: 1'($urandom), value: VALUE_W'($urandom)};
			repeat (n) @(posedge clk);
		end
	endtask

	// Send in bursts of random length separated by random gaps
	task automatic send_bursty(input logic op, input logic [VALUE_W-1:0] v);
		send(op, v);
		if (burst_left <= 0) begin
			pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
			burst_left = $urandom_range(1, 40);
		end else begin
			burst_left--;
		end
	endtask

	// Random commands at a given push share; optionally stop once the heap is full
	task automatic run_phase(input int n, input int push_pct, input bit stop_when_full);
		logic op;
		for (int i = 0; i < n; i++) begin
			if (stop_when_full && shadow.fill >= HEAP_DEPTH)
				break;
			op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
			send_bursty(op, pick_value());
		end
	endtask

	initial begin
		shadow = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, zero and maximum values, equal keys, right child past size
		send_bursty(OP_POP, VALUE_MAX);
		send_bursty(OP_PUSH, '0);
		send_bursty(OP_PUSH, VALUE_MAX);
		send_bursty(OP_PUSH, VALUE_W'(5));
		send_bursty(OP_PUSH, VALUE_W'(5));
		send_bursty(OP_PUSH, VALUE_W'(3));
		send_bursty(OP_PUSH, VALUE_MAX);
		repeat (6) send_bursty(OP_POP, '0);
		send_bursty(OP_POP, '0);
		send_bursty(OP_PUSH, VALUE_W'(10));
		send_bursty(OP_PUSH, VALUE_W'(20));
		send_bursty(OP_PUSH, VALUE_W'(7));
		send_bursty(OP_POP, '0);
		send_bursty(OP_POP, '0);
		send_bursty(OP_PUSH, VALUE_W'(20));
		send_bursty(OP_PUSH, VALUE_W'(20));
		send_bursty(OP_POP, '0);

		// Random: balanced mix, fill to full, hover at full, then drain
		run_phase(150, 50, 1'b0);
		run_phase(2000, 95, 1'b1);
		run_phase(60, 65, 1'b0);
		run_phase(120, 20, 1'b0);
		pause(1);

		// Drain outstanding beats, then watch for strays
		while (shadow.awaited_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (shadow.mismatches == 0 && shadow.awaited_beats.size() == 0)
			$display("tb_binary_min_heap_queue OK");
		else
			$display("tb_binary_min_heap_queue NOT OK");
		$finish;
	end

endmodule
